FILE: src/row_range_segment_table_defines.svh
// assertion macros for the segment table checker
// used by rrst_checker only; no other dependencies
`ifndef ROW_RANGE_SEGMENT_TABLE_DEFINES_SVH
`define ROW_RANGE_SEGMENT_TABLE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define RRST_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define RRST_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/rrst_pkg.sv
// shared types, codes and helpers for the row range segment table
// no dependencies; used by every other file of the block but the assertion macros header
package rrst_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    // signed search bounds: lo in 0..depth, hi in -1..depth-1
    localparam int PTR_W       = CNT_W + 1;
    // signed width for position arithmetic against the fill count
    localparam int GW          = ((CNT_W > 10) ? CNT_W : 10) + 2;

    localparam int ROW_W = 48;
    localparam int RCNT_W = 32;
    localparam int HDL_W = 32;

    // entry count reported when the table is full
    localparam logic [8:0] FULL_COUNT9 = 9'(TABLE_DEPTH);

    typedef enum logic [2:0] {
        REQ_APPEND = 3'd0,
        REQ_FIND   = 3'd1,
        REQ_GET    = 3'd2,
        REQ_LAST   = 3'd3,
        REQ_HAS    = 3'd4,
        REQ_TRUNC  = 3'd5
    } t_req;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADDR,
        S_CMP,
        S_PUSH
    } t_state;

    typedef struct packed {
        logic [ROW_W-1:0]  start_row;
        logic [RCNT_W-1:0] row_count;
        logic [HDL_W-1:0]  handle;
    } t_entry;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
    } t_mem_ctl;

    // index to the 8-bit position field
    function automatic logic [7:0] fit_pos(input logic [IDX_W-1:0] v);
        logic [IDX_W+7:0] t;
        t = (IDX_W + 8)'(v);
        return t[7:0];
    endfunction

    // fill count to the 9-bit entry count field
    function automatic logic [8:0] fit_cnt(input logic [CNT_W-1:0] v);
        logic [CNT_W+8:0] t;
        t = (CNT_W + 9)'(v);
        return t[8:0];
    endfunction

endpackage

FILE: src/rrst_if.sv
// request and response channel interfaces of the segment table
// depends on rrst_pkg for field widths
interface rrst_req_if;
    logic                        valid;
    logic                        ready;
    logic [2:0]                  req_type;
    logic [rrst_pkg::ROW_W-1:0]  lookup_row;
    logic [rrst_pkg::RCNT_W-1:0] row_count;
    logic [rrst_pkg::HDL_W-1:0]  seg_handle;
    logic signed [9:0]           position;

    modport source (output valid, req_type, lookup_row, row_count, seg_handle, position,
                    input ready);
    modport sink (input valid, req_type, lookup_row, row_count, seg_handle, position,
                  output ready);
endinterface

interface rrst_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 status;
    logic [rrst_pkg::HDL_W-1:0] out_handle;
    logic [7:0]                 out_position;
    logic [8:0]                 entry_count;

    modport source (output valid, status, out_handle, out_position, entry_count,
                    input ready);
    modport sink (input valid, status, out_handle, out_position, entry_count,
                  output ready);
endinterface

FILE: src/rrst_table_mem.sv
// entry storage: one write port, one read port with registered read data
// depends on rrst_pkg for the entry type and depth
module rrst_table_mem (
    input  logic              i_clk,
    input  rrst_pkg::t_mem_ctl i_ctl,
    input  rrst_pkg::t_entry   i_wr_data,
    output rrst_pkg::t_entry   o_rd_data
);

    rrst_pkg::t_entry r_mem [rrst_pkg::TABLE_DEPTH];
    rrst_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_ctl.wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_ctl.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: src/row_range_segment_table.sv
// top level of the row range segment table
// depends on rrst_pkg, rrst_if and rrst_table_mem
//
// Ordered table of up to 256 segments (start row, row count, handle) kept in
// append order in a single-port-read entry memory. One request is worked at a
// time and i_req.ready is low until its result is in the output register; a
// new request may be taken while that result still waits for o_rsp.ready.
// Append, truncate and unknown codes need no memory read. Get by position and
// get last make at most one memory read. Find by row is a binary search that
// reuses one read port and one 49-bit range compare, at most log2(depth)+1
// probes. Has handle is a linear scan through the same read port and compare,
// one probe per entry. The memory needs no clearing: only entries below the
// fill count are ever read.
module row_range_segment_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rrst_req_if.sink    i_req,
    rrst_rsp_if.source  o_rsp
);

    localparam int IDX_W = rrst_pkg::IDX_W;
    localparam int CNT_W = rrst_pkg::CNT_W;
    localparam int PTR_W = rrst_pkg::PTR_W;
    localparam int GW    = rrst_pkg::GW;

    typedef struct packed {
        logic below;
        logic beyond;
        logic hdl_eq;
    } t_cmp;

    // control state
    rrst_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic             r_out_valid, n_out_valid;

    // working registers
    rrst_pkg::t_req            r_req, n_req;
    logic [rrst_pkg::ROW_W-1:0] r_row, n_row;
    logic [rrst_pkg::HDL_W-1:0] r_hdl, n_hdl;
    logic signed [PTR_W-1:0]   r_lo, n_lo;
    logic signed [PTR_W-1:0]   r_hi, n_hi;
    logic [IDX_W-1:0]          r_idx, n_idx;
    rrst_pkg::t_status         r_res_status, n_res_status;
    logic [rrst_pkg::HDL_W-1:0] r_res_handle, n_res_handle;
    logic [7:0]                r_res_pos, n_res_pos;

    // output register
    rrst_pkg::t_status          r_out_status, n_out_status;
    logic [rrst_pkg::HDL_W-1:0] r_out_handle, n_out_handle;
    logic [7:0]                 r_out_pos, n_out_pos;
    logic [8:0]                 r_out_count, n_out_count;

    rrst_pkg::t_mem_ctl w_mem_ctl;
    rrst_pkg::t_entry   w_wr_data;
    rrst_pkg::t_entry   w_rd_data;

    logic                    w_accept;
    rrst_pkg::t_req          w_in_req;
    logic                    w_full;
    logic                    w_slot_free;
    logic signed [PTR_W:0]   w_sum;
    logic signed [PTR_W:0]   w_mid_s;
    logic [IDX_W-1:0]        w_mid;
    logic signed [PTR_W-1:0] w_fill_p;
    logic signed [PTR_W-1:0] w_idx_p;
    logic signed [GW-1:0]    w_pos_g;
    logic signed [GW-1:0]    w_fill_g;
    logic signed [GW-1:0]    w_get_g;
    logic signed [GW-1:0]    w_pos_p1;
    logic                    w_get_ok;
    logic                    w_trunc_do;
    logic                    w_probe_go;
    logic                    w_cmp_hit;
    logic [rrst_pkg::ROW_W:0] w_end;
    t_cmp                    w_cmp;

    assign w_accept    = i_req.valid && i_req.ready;
    assign w_in_req    = rrst_pkg::t_req'(i_req.req_type);
    assign w_full      = (r_fill == CNT_W'(rrst_pkg::TABLE_DEPTH));
    assign w_slot_free = !r_out_valid || o_rsp.ready;

    // binary search midpoint
    assign w_sum   = (PTR_W + 1)'(r_lo) + (PTR_W + 1)'(r_hi);
    assign w_mid_s = w_sum >>> 1;
    assign w_mid   = w_mid_s[IDX_W-1:0];

    assign w_fill_p = signed'(PTR_W'(r_fill));
    assign w_idx_p  = signed'(PTR_W'(r_idx));

    // signed position against the fill count
    assign w_pos_g    = GW'(i_req.position);
    assign w_fill_g   = signed'(GW'(r_fill));
    assign w_get_g    = (w_pos_g < 0) ? (w_fill_g + w_pos_g) : w_pos_g;
    assign w_get_ok   = (w_get_g >= 0) && (w_get_g < w_fill_g);
    assign w_pos_p1   = w_pos_g + GW'(1);
    assign w_trunc_do = (w_pos_g >= 0) && (r_fill != '0)
                        && (w_pos_g < (w_fill_g - GW'(1)));

    // shared compare unit on the entry just read
    assign w_end         = {1'b0, w_rd_data.start_row}
                           + (rrst_pkg::ROW_W + 1)'(w_rd_data.row_count);
    assign w_cmp.below   = (r_row < w_rd_data.start_row);
    assign w_cmp.beyond  = ({1'b0, r_row} >= w_end);
    assign w_cmp.hdl_eq  = (r_hdl == w_rd_data.handle);

    always_comb begin
        unique case (r_req)
            rrst_pkg::REQ_FIND: w_probe_go = (r_lo <= r_hi);
            rrst_pkg::REQ_HAS:  w_probe_go = (r_lo < w_fill_p);
            default:            w_probe_go = 1'b1;
        endcase
    end

    always_comb begin
        unique case (r_req)
            rrst_pkg::REQ_FIND: w_cmp_hit = !w_cmp.below && !w_cmp.beyond;
            rrst_pkg::REQ_HAS:  w_cmp_hit = w_cmp.hdl_eq;
            default:            w_cmp_hit = 1'b1;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rrst_pkg::S_IDLE: begin
                if (w_accept) begin
                    unique case (w_in_req)
                        rrst_pkg::REQ_FIND,
                        rrst_pkg::REQ_HAS:  n_state = rrst_pkg::S_ADDR;
                        rrst_pkg::REQ_GET:  n_state = w_get_ok ? rrst_pkg::S_ADDR
                                                               : rrst_pkg::S_PUSH;
                        rrst_pkg::REQ_LAST: n_state = (r_fill != '0) ? rrst_pkg::S_ADDR
                                                                     : rrst_pkg::S_PUSH;
                        default:            n_state = rrst_pkg::S_PUSH;
                    endcase
                end
            end
            rrst_pkg::S_ADDR: begin
                n_state = w_probe_go ? rrst_pkg::S_CMP : rrst_pkg::S_PUSH;
            end
            rrst_pkg::S_CMP: begin
                n_state = w_cmp_hit ? rrst_pkg::S_PUSH : rrst_pkg::S_ADDR;
            end
            rrst_pkg::S_PUSH: begin
                if (w_slot_free) begin
                    n_state = rrst_pkg::S_IDLE;
                end
            end
            default: n_state = rrst_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_fill       = r_fill;
        n_req        = r_req;
        n_row        = r_row;
        n_hdl        = r_hdl;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_idx        = r_idx;
        n_res_status = r_res_status;
        n_res_handle = r_res_handle;
        n_res_pos    = r_res_pos;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_handle = r_out_handle;
        n_out_pos    = r_out_pos;
        n_out_count  = r_out_count;

        w_mem_ctl.wr_en   = 1'b0;
        w_mem_ctl.wr_addr = r_fill[IDX_W-1:0];
        w_mem_ctl.rd_en   = 1'b0;
        w_mem_ctl.rd_addr = (r_req == rrst_pkg::REQ_FIND) ? w_mid : r_lo[IDX_W-1:0];

        w_wr_data.start_row = i_req.lookup_row;
        w_wr_data.row_count = i_req.row_count;
        w_wr_data.handle    = i_req.seg_handle;

        unique case (r_state)
            rrst_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_req        = w_in_req;
                    n_row        = i_req.lookup_row;
                    n_hdl        = i_req.seg_handle;
                    n_res_status = rrst_pkg::ST_NOT_FOUND;
                    n_res_handle = '0;
                    n_res_pos    = '0;
                    unique case (w_in_req)
                        rrst_pkg::REQ_APPEND: begin
                            if (w_full) begin
                                n_res_status = rrst_pkg::ST_FULL;
                            end else begin
                                w_mem_ctl.wr_en = 1'b1;
                                n_fill          = r_fill + CNT_W'(1);
                                n_res_status    = rrst_pkg::ST_OK;
                                n_res_handle    = i_req.seg_handle;
                                n_res_pos       = rrst_pkg::fit_pos(r_fill[IDX_W-1:0]);
                            end
                        end
                        rrst_pkg::REQ_FIND: begin
                            n_lo = '0;
                            n_hi = w_fill_p - PTR_W'(1);
                        end
                        rrst_pkg::REQ_GET: begin
                            n_lo = signed'(w_get_g[PTR_W-1:0]);
                        end
                        rrst_pkg::REQ_LAST: begin
                            n_lo = w_fill_p - PTR_W'(1);
                        end
                        rrst_pkg::REQ_HAS: begin
                            n_lo = '0;
                        end
                        rrst_pkg::REQ_TRUNC: begin
                            if (w_trunc_do) begin
                                n_fill = w_pos_p1[CNT_W-1:0];
                            end
                            n_res_status = rrst_pkg::ST_OK;
                        end
                        default: begin
                            n_res_status = rrst_pkg::ST_NOT_FOUND;
                        end
                    endcase
                end
            end
            rrst_pkg::S_ADDR: begin
                if (w_probe_go) begin
                    w_mem_ctl.rd_en = 1'b1;
                    n_idx           = w_mem_ctl.rd_addr;
                end
            end
            rrst_pkg::S_CMP: begin
                if (w_cmp_hit) begin
                    n_res_status = rrst_pkg::ST_OK;
                    n_res_handle = w_rd_data.handle;
                    n_res_pos    = rrst_pkg::fit_pos(r_idx);
                end else if (r_req == rrst_pkg::REQ_FIND) begin
                    if (w_cmp.below) begin
                        n_hi = w_idx_p - PTR_W'(1);
                    end else begin
                        n_lo = w_idx_p + PTR_W'(1);
                    end
                end else begin
                    n_lo = r_lo + PTR_W'(1);
                end
            end
            rrst_pkg::S_PUSH: begin
                if (w_slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_handle = r_res_handle;
                    n_out_pos    = r_res_pos;
                    n_out_count  = rrst_pkg::fit_cnt(r_fill);
                end
            end
            default: begin
                n_out_valid = r_out_valid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rrst_pkg::S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_row        <= n_row;
        r_hdl        <= n_hdl;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_idx        <= n_idx;
        r_res_status <= n_res_status;
        r_res_handle <= n_res_handle;
        r_res_pos    <= n_res_pos;
        r_out_status <= n_out_status;
        r_out_handle <= n_out_handle;
        r_out_pos    <= n_out_pos;
        r_out_count  <= n_out_count;
    end

    rrst_table_mem u_mem (
        .i_clk     (i_clk),
        .i_ctl     (w_mem_ctl),
        .i_wr_data (w_wr_data),
        .o_rd_data (w_rd_data)
    );

    assign i_req.ready        = (r_state == rrst_pkg::S_IDLE);
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.out_handle   = r_out_handle;
    assign o_rsp.out_position = r_out_pos;
    assign o_rsp.entry_count  = r_out_count;

endmodule

FILE: src/rrst_checker.sv
// port-level checks on the segment table, attached by bind
// depends on rrst_pkg and the assertion macros header
`include "row_range_segment_table_defines.svh"

module rrst_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_status,
    input logic [31:0] i_handle,
    input logic [7:0]  i_position,
    input logic [8:0]  i_count
);

    // a stalled result holds
    `RRST_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_status) && $stable(i_handle) && $stable(i_position) && $stable(i_count), "stalled result changed")
    // ready is low in the cycle after every accept
    `RRST_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "ready right after accept")
    // failures carry no handle or position
    `RRST_ASSERT_IMP(a_fail_zero, i_clk, i_rst_n, i_out_valid && (i_status != rrst_pkg::ST_OK), (i_handle == '0) && (i_position == '0), "failed result has payload")
    // full status only with a full table
    `RRST_ASSERT_IMP(a_full_count, i_clk, i_rst_n, i_out_valid && (i_status == rrst_pkg::ST_FULL), i_count == rrst_pkg::FULL_COUNT9, "full status with room left")

endmodule

bind row_range_segment_table rrst_checker u_rrst_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_handle    (o_rsp.out_handle),
    .i_position  (o_rsp.out_position),
    .i_count     (o_rsp.entry_count)
);
